/* hw/rtl/sorted_key_nearest_row_lookup_macros.svh */
// Assertion helpers used by the lookup engine.
`ifndef SORTED_KEY_NEAREST_ROW_LOOKUP_MACROS_SVH
`define SORTED_KEY_NEAREST_ROW_LOOKUP_MACROS_SVH

// Plain invariant, checked at every rising clock edge outside reset.
`define SKNL_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SKNL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SKNL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sknl_pkg.sv */
// ----------------------------------------------------------------------------
// sknl_pkg
// Shared types and codes for the sorted-key nearest-row lookup.
// ----------------------------------------------------------------------------
package sknl_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BITS    = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One queued input word.
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
    } t_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SCMP,
        S_LCMP,
        S_LNEW,
        S_SHIFT,
        S_SHWR,
        S_QA,
        S_QB,
        S_RESP
    } t_state;

endpackage

/* hw/rtl/sknl_front.sv */
// ----------------------------------------------------------------------------
// sknl_front
// Input side: accepts words and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module sknl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  sknl_pkg::t_word i_word,
    output logic           o_q_valid,
    output sknl_pkg::t_word o_q_word,
    input  logic           i_q_pop
);
    import sknl_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_word          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           push, pop;

    assign o_s_ready = (r_cnt != QUEUE_DEPTH[PW:0]);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_word  = r_mem[r_rp];
    assign push      = i_s_valid && o_s_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_word;
    end

endmodule

/* hw/rtl/sknl_engine.sv */
// ----------------------------------------------------------------------------
// sknl_engine
// Back side: sorted table in memory, binary search, insert shift, query
// compare and the output register.
// ----------------------------------------------------------------------------
`include "sorted_key_nearest_row_lookup_macros.svh"

module sknl_engine #(
    parameter int TABLE_DEPTH = sknl_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = sknl_pkg::DEF_KEY_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  sknl_pkg::t_word i_q_word,
    output logic            o_q_pop,
    output logic            o_m_valid,
    input  logic            i_m_ready,
    output logic [31:0]     o_row,
    output logic [1:0]      o_status,
    output logic            o_exact
);
    import sknl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int EW = KW + 32;

    // entry: key in upper bits, row in lower 32
    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rd;

    t_state        r_state, n_state;
    logic [AW:0]   r_count, n_count;
    logic [31:0]   r_next_row, n_next_row;
    logic [AW:0]   r_lo, n_lo, r_hi, n_hi, r_idx, n_idx;
    logic [AW-1:0] r_mid, n_mid;
    logic [1:0]    r_func, n_func;
    logic [KW-1:0] r_v, n_v;
    logic [31:0]   r_r, n_r;
    logic [EW-1:0] r_a, n_a;
    logic [31:0]   r_res_row, n_res_row;
    logic [1:0]    r_res_st, n_res_st;
    logic          r_res_ex, n_res_ex;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_row, n_out_row;
    logic [1:0]    r_out_st, n_out_st;
    logic          r_out_ex, n_out_ex;

    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [AW+1:0] sum;
    logic [KW-1:0] rd_key, a_key, up, dn;

    assign rd_key = r_rd[EW-1:32];
    assign a_key  = r_a[EW-1:32];
    assign sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign up     = a_key - r_v;
    assign dn     = r_v - rd_key;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_next_row  = r_next_row;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_mid       = r_mid;
        n_func      = r_func;
        n_v         = r_v;
        n_r         = r_r;
        n_a         = r_a;
        n_res_row   = r_res_row;
        n_res_st    = r_res_st;
        n_res_ex    = r_res_ex;
        n_out_valid = r_out_valid && !i_m_ready;
        n_out_row   = r_out_row;
        n_out_st    = r_out_st;
        n_out_ex    = r_out_ex;
        o_q_pop     = 1'b0;
        rd_addr     = '0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_func    = i_q_word.func;
                    n_v       = i_q_word.key[KW-1:0];
                    n_r       = r_next_row;
                    n_lo      = '0;
                    n_hi      = r_count;
                    n_res_row = '0;
                    n_res_st  = ST_OK;
                    n_res_ex  = 1'b0;
                    n_state   = S_RESP;
                    case (i_q_word.func)
                        FUNC_CLEAR: begin
                            n_count    = '0;
                            n_next_row = '0;
                        end
                        FUNC_LOAD: begin
                            n_next_row = r_next_row + 32'd1;
                            n_state    = S_SEARCH;
                        end
                        FUNC_QUERY: begin
                            if (r_count == '0) n_res_st = ST_EMPTY;
                            else               n_state  = S_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    n_mid   = sum[AW:1];
                    rd_addr = sum[AW:1];
                    n_state = S_SCMP;
                end else if (r_func == FUNC_LOAD) begin
                    if (r_lo < r_count) begin
                        rd_addr = r_lo[AW-1:0];
                        n_state = S_LCMP;
                    end else begin
                        n_state = S_LNEW;
                    end
                end else begin
                    rd_addr = (r_lo < r_count) ? r_lo[AW-1:0] : r_lo[AW-1:0] - 1'b1;
                    n_state = S_QA;
                end
            end
            S_SCMP: begin
                if (rd_key < r_v) n_lo = {1'b0, r_mid} + 1'b1;
                else              n_hi = {1'b0, r_mid};
                n_state = S_SEARCH;
            end
            S_LCMP: begin
                n_state = (rd_key == r_v) ? S_RESP : S_LNEW;
            end
            S_LNEW: begin
                if (r_count >= TABLE_DEPTH[AW:0]) begin
                    n_res_st = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_idx   = r_count;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_idx == r_lo) begin
                    we      = 1'b1;
                    waddr   = r_idx[AW-1:0];
                    wdata   = {r_v, r_r};
                    n_count = r_count + 1'b1;
                    n_state = S_RESP;
                end else begin
                    rd_addr = r_idx[AW-1:0] - 1'b1;
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                we      = 1'b1;
                waddr   = r_idx[AW-1:0];
                wdata   = r_rd;
                n_idx   = r_idx - 1'b1;
                n_state = S_SHIFT;
            end
            S_QA: begin
                n_a       = r_rd;
                n_res_row = r_rd[31:0];
                n_res_ex  = (rd_key == r_v);
                if (r_lo == '0 || r_lo == r_count || rd_key == r_v) begin
                    n_state = S_RESP;
                end else begin
                    rd_addr = r_lo[AW-1:0] - 1'b1;
                    n_state = S_QB;
                end
            end
            S_QB: begin
                // tie goes to the lower key
                n_res_row = (up < dn) ? r_a[31:0] : r_rd[31:0];
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_m_ready) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_res_row;
                    n_out_st    = r_res_st;
                    n_out_ex    = r_res_ex;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_row  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_row  <= n_next_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_idx     <= n_idx;
        r_mid     <= n_mid;
        r_func    <= n_func;
        r_v       <= n_v;
        r_r       <= n_r;
        r_a       <= n_a;
        r_res_row <= n_res_row;
        r_res_st  <= n_res_st;
        r_res_ex  <= n_res_ex;
        r_out_row <= n_out_row;
        r_out_st  <= n_out_st;
        r_out_ex  <= n_out_ex;
    end

    assign o_m_valid = r_out_valid;
    assign o_row     = r_out_row;
    assign o_status  = r_out_st;
    assign o_exact   = r_out_ex;

    `SKNL_ASSERT(a_count_bound, r_count <= TABLE_DEPTH[AW:0], "entry count over depth")
    `SKNL_ASSERT_IMP(a_shift_above_pos, r_state == S_SHWR, r_idx > r_lo, "shift below pos")
    `SKNL_ASSERT_NXT(a_insert_count, r_state == S_SHIFT && r_idx == r_lo, r_count == $past(r_count) + 1'b1, "insert did not bump count")
    `SKNL_ASSERT_IMP(a_pop_idle, o_q_pop, r_state == S_IDLE && i_q_valid, "pop outside idle")

endmodule

/* hw/rtl/sorted_key_nearest_row_lookup.sv */
// Clear, unused func and empty query go straight to the response. Query: binary
// search, then the clamped or exact entry or the nearer of two neighbours. Load:
// binary search; a repeat or a full table is dropped, else entries above the slot
// move up one place and the key is inserted. One word at a time: the engine pops
// the next word only after the last result has gone into the output register.
// Reset: synchronous active low; empties the table and zeroes the row number.
// ----------------------------------------------------------------------------
// sorted_key_nearest_row_lookup
// Sorted table of distinct keys with first-load rows; nearest-key query.
// ----------------------------------------------------------------------------
module sorted_key_nearest_row_lookup #(
    parameter int TABLE_DEPTH = sknl_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = sknl_pkg::DEF_KEY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] key
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] row
    output logic [2:0]  o_m_axis_tuser    // [1:0] status, [2] exact
);
    import sknl_pkg::*;

    t_word in_word, q_word;
    logic  q_valid, q_pop;
    logic  [1:0] status;
    logic  exact;

    assign in_word.func = i_s_axis_tuser;
    assign in_word.key  = i_s_axis_tdata;

    // front: word queue so the input keeps flowing while the engine works, until the queue is full
    sknl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_word    (in_word),
        .o_q_valid (q_valid),
        .o_q_word  (q_word),
        .i_q_pop   (q_pop)
    );

    // back: table, search, shift and result register
    sknl_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_word  (q_word),
        .o_q_pop   (q_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_row     (o_m_axis_tdata),
        .o_status  (status),
        .o_exact   (exact)
    );

    assign o_m_axis_tuser = {exact, status};

endmodule
